// ===== sv/hse_pkg.sv =====
// package: shared widths, codes and control types for the household seir event selector
`timescale 1ns / 1ps

package hse_pkg;

    localparam int HSE_HOUSE_SIZE_DEF = 7;
    localparam int HSE_COUNT_BITS_DEF = 20;

    localparam int CMD_W      = 3;
    localparam int DRAW_W     = 26;
    localparam int PICK_W     = 4;
    localparam int TOTAL_W    = 24;
    localparam int PAIR_W     = 26;
    localparam int HC_W       = 20;
    localparam int MPH_W      = 3;
    localparam int POP_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_INIT      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OUTSIDE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSIDE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INFECTION = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECOVERY  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HOUSEHOLD_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBERS         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POPULATION      = 2'd2;

    localparam int TOT_S = 0;
    localparam int TOT_E = 1;
    localparam int TOT_I = 2;
    localparam int TOT_R = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [PAIR_W-1:0]  PAIR_MAX  = '1;

    typedef enum logic [3:0] {
        ST_RST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MOVE_SRC,
        ST_MOVE_DST,
        ST_UPDATE,
        ST_INIT_CLEAR,
        ST_SEED_A,
        ST_SEED_B,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic take;
        logic clear;
        logic scan;
        logic move_src;
        logic move_dst;
        logic update;
        logic seed_a;
        logic seed_b;
        logic load_out;
    } t_dp_ctl;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic found;
    } t_dp_sts;

endpackage

// ===== sv/hse_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hse_ctrl.sv =====
// controller: sequences clearing, seeding, scan, move, update and result hand-off
`timescale 1ns / 1ps

module hse_ctrl
    import hse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_out_stall,
    input  t_dp_sts          i_sts,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_dp_ctl          o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_ctl       = '0;
        o_in_stall  = 1'b1;
        case (r_state)
            ST_RST_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    if (i_cmd == CMD_INIT) begin
                        n_state = ST_INIT_CLEAR;
                    end else if (i_cmd inside {[CMD_OUTSIDE:CMD_RECOVERY]}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.found ? ST_MOVE_SRC : ST_UPDATE;
                end
            end
            ST_MOVE_SRC: begin
                o_ctl.move_src = 1'b1;
                n_state        = ST_MOVE_DST;
            end
            ST_MOVE_DST: begin
                o_ctl.move_dst = 1'b1;
                n_state        = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_INIT_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_SEED_A;
                end
            end
            ST_SEED_A: begin
                o_ctl.seed_a = 1'b1;
                n_state      = ST_SEED_B;
            end
            ST_SEED_B: begin
                o_ctl.seed_b = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/hse_datapath.sv =====
// datapath: household table, scan pipeline, totals, pair weight and result registers
`timescale 1ns / 1ps

module hse_datapath
    import hse_pkg::*;
#(
    parameter int HOUSE_SIZE = HSE_HOUSE_SIZE_DEF,
    parameter int COUNT_BITS = HSE_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_ctl               i_ctl,
    output t_dp_sts               o_sts,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [DRAW_W-1:0]     i_draw,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_found,
    output logic [PICK_W-1:0]     o_picked_susceptible,
    output logic [PICK_W-1:0]     o_picked_infected,
    output logic [PICK_W-1:0]     o_picked_exposed,
    output logic [TOTAL_W-1:0]    o_susceptible_total,
    output logic [TOTAL_W-1:0]    o_exposed_total,
    output logic [TOTAL_W-1:0]    o_infected_total,
    output logic [TOTAL_W-1:0]    o_recovered_total,
    output logic [PAIR_W-1:0]     o_pair_weight
);

    localparam int SIDE    = HOUSE_SIZE + 1;
    localparam int CELLS   = SIDE * SIDE * SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CW      = $clog2(SIDE);
    localparam int SUM_W   = CW + 2;
    localparam int FACT_W  = 2 * CW;
    localparam int W_W     = COUNT_BITS + FACT_W;
    localparam int CUM_RAW = W_W + ADDR_W;
    localparam int CUM_W   = (CUM_RAW > DRAW_W) ? CUM_RAW : DRAW_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_HS    = SUM_W'(HOUSE_SIZE);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] s,
                                                    input logic [CW-1:0] i,
                                                    input logic [CW-1:0] e);
        return ADDR_W'(s) * ADDR_W'(SIDE * SIDE) + ADDR_W'(i) * ADDR_W'(SIDE)
               + ADDR_W'(e);
    endfunction

    // configuration
    logic [HC_W-1:0]   r_hc;
    logic [MPH_W-1:0]  r_mph;
    logic [POP_W-1:0]  r_pop;

    // item
    logic [CMD_W-1:0]  r_cmd;
    logic [DRAW_W-1:0] r_draw;

    // scan counter and pipeline
    logic [CW-1:0]     r_s, r_i, r_e;
    logic              r_issue_done;
    logic              r_p1_valid;
    logic [CW-1:0]     r_p1_s, r_p1_i, r_p1_e;
    logic              r_p2_valid;
    logic [CW-1:0]     r_p2_s, r_p2_i, r_p2_e;
    logic [W_W-1:0]    r_p2_w;
    logic [COUNT_BITS-1:0] r_p2_count;
    logic [CUM_W-1:0]  r_cum;

    // pick
    logic              r_found;
    logic [CW-1:0]     r_ps, r_pi, r_pe;
    logic [COUNT_BITS-1:0] r_pcount;

    // architectural totals
    logic [TOTAL_W-1:0] r_tot [4];
    logic [PAIR_W-1:0]  r_pair;

    logic [ADDR_W-1:0] r_clr_addr;

    // result registers
    logic               r_o_found;
    logic [PICK_W-1:0]  r_o_ps, r_o_pi, r_o_pe;
    logic [TOTAL_W-1:0] r_o_tot [4];
    logic [PAIR_W-1:0]  r_o_pair;

    // ram ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    logic                  issue;
    logic [SUM_W-1:0]      sum_sie;
    logic [SUM_W-1:0]      sum_ie;
    logic [FACT_W-1:0]     fac;
    logic [CUM_W-1:0]      cum_sum;
    logic                  hit;
    logic [CW-1:0]         d_s, d_i, d_e;
    logic [CW-1:0]         m_val;
    logic [HC_W-1:0]       hc_m1;
    logic [COUNT_BITS-1:0] dst_inc;

    hse_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign issue   = i_ctl.scan && !r_issue_done && !r_found;
    assign sum_sie = SUM_W'(r_s) + SUM_W'(r_i) + SUM_W'(r_e);
    assign sum_ie  = SUM_W'(r_i) + SUM_W'(r_e);

    // weight factor of the cell now leaving the ram
    always_comb begin
        case (r_cmd)
            CMD_OUTSIDE:   fac = FACT_W'(r_p1_s);
            CMD_INSIDE:    fac = FACT_W'(r_p1_s) * FACT_W'(r_p1_i);
            CMD_INFECTION: fac = FACT_W'(r_p1_e);
            CMD_RECOVERY:  fac = FACT_W'(r_p1_i);
            default:       fac = '0;
        endcase
    end

    assign cum_sum = r_cum + CUM_W'(r_p2_w);
    assign hit     = r_p2_valid && !r_found && (r_p2_w != '0)
                     && (CUM_W'(r_draw) <= cum_sum);

    // destination cell of the move
    always_comb begin
        d_s = r_ps;
        d_i = r_pi;
        d_e = r_pe;
        case (r_cmd)
            CMD_OUTSIDE, CMD_INSIDE: begin
                d_s = r_ps - 1'b1;
                d_e = r_pe + 1'b1;
            end
            CMD_INFECTION: begin
                d_i = r_pi + 1'b1;
                d_e = r_pe - 1'b1;
            end
            CMD_RECOVERY: begin
                d_i = r_pi - 1'b1;
            end
            default: begin
                d_s = r_ps;
            end
        endcase
    end

    always_comb begin
        if (r_mph == '0) begin
            m_val = CW'(1);
        end else if (32'(r_mph) > 32'(HOUSE_SIZE)) begin
            m_val = CW'(HOUSE_SIZE);
        end else begin
            m_val = CW'(r_mph);
        end
    end

    assign hc_m1   = (r_hc == '0) ? '0 : r_hc - 1'b1;
    assign dst_inc = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '0;
        ram_raddr = cell_addr(r_s, r_i, r_e);
        if (i_ctl.clear) begin
            ram_we = 1'b1;
        end
        if (i_ctl.move_src) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(r_ps, r_pi, r_pe);
            ram_wdata = r_pcount - 1'b1;
            ram_raddr = cell_addr(d_s, d_i, d_e);
        end
        if (i_ctl.move_dst) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(d_s, d_i, d_e);
            ram_wdata = dst_inc;
        end
        if (i_ctl.seed_a) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(m_val, CW'(0), CW'(0));
            ram_wdata = COUNT_BITS'(hc_m1);
        end
        if (i_ctl.seed_b) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(m_val - 1'b1, CW'(1), CW'(0));
            ram_wdata = COUNT_BITS'(1);
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(CELLS - 1));
    assign o_sts.scan_done = r_found || (r_issue_done && !r_p1_valid && !r_p2_valid);
    assign o_sts.found     = r_found;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc         <= HC_W'(1);
            r_mph        <= MPH_W'(4);
            r_pop        <= POP_W'(4);
            r_clr_addr   <= '0;
            r_issue_done <= 1'b0;
            r_p1_valid   <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_pair       <= '0;
            for (int k = 0; k < 4; k++) begin
                r_tot[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HOUSEHOLD_COUNT: r_hc  <= i_cfg_data[HC_W-1:0];
                    CFG_MEMBERS:         r_mph <= i_cfg_data[MPH_W-1:0];
                    CFG_POPULATION:      r_pop <= i_cfg_data[POP_W-1:0];
                    default:             r_hc  <= r_hc;
                endcase
            end

            if (i_ctl.clear) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + 1'b1;
            end

            r_p1_valid <= issue && !i_ctl.take;
            r_p2_valid <= r_p1_valid && !r_found && !i_ctl.take;

            if (i_ctl.take) begin
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
            end else begin
                if (issue && sum_sie >= SUM_HS && sum_ie >= SUM_HS
                        && 32'(r_e) >= 32'(HOUSE_SIZE)) begin
                    r_issue_done <= 1'b1;
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end

            if (i_ctl.update) begin
                if (r_found) begin
                    case (r_cmd)
                        CMD_OUTSIDE, CMD_INSIDE: begin
                            r_pair <= (r_pair > PAIR_W'(r_pi)) ? r_pair - PAIR_W'(r_pi) : '0;
                        end
                        CMD_INFECTION: begin
                            r_pair <= ((PAIR_W + 1)'(r_pair) + (PAIR_W + 1)'(r_ps)
                                       > (PAIR_W + 1)'(PAIR_MAX))
                                      ? PAIR_MAX : r_pair + PAIR_W'(r_ps);
                        end
                        default: begin
                            r_pair <= (r_pair > PAIR_W'(r_ps)) ? r_pair - PAIR_W'(r_ps) : '0;
                        end
                    endcase
                end
                case (r_cmd)
                    CMD_OUTSIDE, CMD_INSIDE: begin
                        r_tot[TOT_S] <= (r_tot[TOT_S] == '0) ? '0 : r_tot[TOT_S] - 1'b1;
                        r_tot[TOT_E] <= (r_tot[TOT_E] == TOTAL_MAX) ? TOTAL_MAX
                                        : r_tot[TOT_E] + 1'b1;
                    end
                    CMD_INFECTION: begin
                        r_tot[TOT_E] <= (r_tot[TOT_E] == '0) ? '0 : r_tot[TOT_E] - 1'b1;
                        r_tot[TOT_I] <= (r_tot[TOT_I] == TOTAL_MAX) ? TOTAL_MAX
                                        : r_tot[TOT_I] + 1'b1;
                    end
                    default: begin
                        r_tot[TOT_I] <= (r_tot[TOT_I] == '0) ? '0 : r_tot[TOT_I] - 1'b1;
                        r_tot[TOT_R] <= (r_tot[TOT_R] == TOTAL_MAX) ? TOTAL_MAX
                                        : r_tot[TOT_R] + 1'b1;
                    end
                endcase
            end

            if (i_ctl.seed_b) begin
                r_tot[TOT_S] <= (r_pop == '0) ? '0 : TOTAL_W'(r_pop - 1'b1);
                r_tot[TOT_E] <= '0;
                r_tot[TOT_I] <= TOTAL_W'(1);
                r_tot[TOT_R] <= '0;
                r_pair       <= PAIR_W'(m_val - 1'b1);
            end
        end
    end

    // scan counter walks e, then i, then s innermost over s + i + e <= size
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd  <= i_cmd;
            r_draw <= i_draw;
            r_s    <= '0;
            r_i    <= '0;
            r_e    <= '0;
            r_cum  <= '0;
        end else begin
            if (issue) begin
                if (sum_sie < SUM_HS) begin
                    r_s <= r_s + 1'b1;
                end else if (sum_ie < SUM_HS) begin
                    r_s <= '0;
                    r_i <= r_i + 1'b1;
                end else if (32'(r_e) < 32'(HOUSE_SIZE)) begin
                    r_s <= '0;
                    r_i <= '0;
                    r_e <= r_e + 1'b1;
                end
            end
            if (r_p2_valid && !r_found) begin
                r_cum <= cum_sum;
            end
        end

        r_p1_s <= r_s;
        r_p1_i <= r_i;
        r_p1_e <= r_e;

        r_p2_s     <= r_p1_s;
        r_p2_i     <= r_p1_i;
        r_p2_e     <= r_p1_e;
        r_p2_count <= ram_rdata;
        r_p2_w     <= W_W'(ram_rdata) * W_W'(fac);

        if (hit) begin
            r_ps     <= r_p2_s;
            r_pi     <= r_p2_i;
            r_pe     <= r_p2_e;
            r_pcount <= r_p2_count;
        end

        if (i_ctl.load_out) begin
            r_o_found <= r_found;
            r_o_ps    <= r_found ? PICK_W'(r_ps) : '0;
            r_o_pi    <= r_found ? PICK_W'(r_pi) : '0;
            r_o_pe    <= r_found ? PICK_W'(r_pe) : '0;
            for (int k = 0; k < 4; k++) begin
                r_o_tot[k] <= r_tot[k];
            end
            r_o_pair <= r_pair;
        end
    end

    assign o_found              = r_o_found;
    assign o_picked_susceptible = r_o_ps;
    assign o_picked_infected    = r_o_pi;
    assign o_picked_exposed     = r_o_pe;
    assign o_susceptible_total  = r_o_tot[TOT_S];
    assign o_exposed_total      = r_o_tot[TOT_E];
    assign o_infected_total     = r_o_tot[TOT_I];
    assign o_recovered_total    = r_o_tot[TOT_R];
    assign o_pair_weight        = r_o_pair;

endmodule

// ===== sv/household_seir_event_select.sv =====
// top level: household seir event selector
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_cmd, i_draw
//   out      output     o_out_valid / i_out_stall o_found, o_picked_*, o_*_total, o_pair_weight
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// an event item reads the table with one table read per cycle through the scan pipeline,
// then, if a cell was picked, does a read-modify-write of two cells.
// an init item runs the one-entry-per-cycle table clear, then seeds the table.
// after reset the table is cleared with the input stalled.
// one item is in work at a time; the next item is taken while a result waits at the output.
`timescale 1ns / 1ps

module household_seir_event_select
    import hse_pkg::*;
#(
    parameter int HOUSE_SIZE = HSE_HOUSE_SIZE_DEF,
    parameter int COUNT_BITS = HSE_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [DRAW_W-1:0]     i_draw,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [PICK_W-1:0]     o_picked_susceptible,
    output logic [PICK_W-1:0]     o_picked_infected,
    output logic [PICK_W-1:0]     o_picked_exposed,
    output logic [TOTAL_W-1:0]    o_susceptible_total,
    output logic [TOTAL_W-1:0]    o_exposed_total,
    output logic [TOTAL_W-1:0]    o_infected_total,
    output logic [TOTAL_W-1:0]    o_recovered_total,
    output logic [PAIR_W-1:0]     o_pair_weight,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    hse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    hse_datapath #(
        .HOUSE_SIZE (HOUSE_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (ctl),
        .o_sts                (sts),
        .i_cmd                (i_cmd),
        .i_draw               (i_draw),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_found              (o_found),
        .o_picked_susceptible (o_picked_susceptible),
        .o_picked_infected    (o_picked_infected),
        .o_picked_exposed     (o_picked_exposed),
        .o_susceptible_total  (o_susceptible_total),
        .o_exposed_total      (o_exposed_total),
        .o_infected_total     (o_infected_total),
        .o_recovered_total    (o_recovered_total),
        .o_pair_weight        (o_pair_weight)
    );

endmodule
